// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while aresetn is low.
`define UWFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while aresetn is low.
`define UWFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define UWFS_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uwfs_pkg.sv =====
// Package of the whitespace field splitter: item types, queue record, decode helpers.
package uwfs_pkg;

    localparam longint unsigned MAX_TEXT_LEN_DEF = 64'd65536;
    localparam int START_W     = 16;
    localparam int END_W       = 17;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [START_W-1:0] field_start;
        logic [END_W-1:0]   field_end;
        logic               closes_stream;
    } out_item_t;

    // Class of the one character that a byte completes, if any
    typedef enum logic [1:0] {
        MARK_NONE  = 2'b00,
        MARK_SPACE = 2'b01,
        MARK_TEXT  = 2'b10
    } mark_kind_t;

    // What the front tells the back about one accepted byte
    typedef struct packed {
        logic               err_lead;    // held lead broke: text rune at err_off
        logic [START_W-1:0] err_off;
        mark_kind_t         main_kind;
        logic [END_W-1:0]   main_off;
        logic               last;
        logic               tail_valid;  // bytes still held at end of stream
        logic [START_W-1:0] tail_off;
        logic [END_W-1:0]   end_off;
    } step_rec_t;

    function automatic logic ascii_space(input logic [7:0] b);
        return (b inside {8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20});
    endfunction

    function automatic logic rune_space(input logic [20:0] r);
        logic res;
        if (r < 21'h80) begin
            res = ascii_space(r[7:0]);
        end else begin
            res = (r inside {21'h85, 21'hA0, 21'h1680, [21'h2000:21'h200A],
                             21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000});
        end
        return res;
    endfunction

    // Total length of a sequence led by b, zero for a byte that cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b inside {[8'hC2:8'hDF]}) begin
            len = 3'd2;
        end else if (b inside {[8'hE0:8'hEF]}) begin
            len = 3'd3;
        end else if (b inside {[8'hF0:8'hF4]}) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Does b continue a sequence led by lead with held bytes already in?
    function automatic logic continues(input logic [7:0] lead, input logic [1:0] held,
                                       input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (held == 2'd1) begin
            case (lead)
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
            endcase
        end
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

// ===== sv/uwfs_front.sv =====
// Front of the splitter: UTF-8 decode, byte offsets, one record per accepted byte.
module uwfs_front
    import uwfs_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      rec_valid,
    input  logic      rec_ready,
    output step_rec_t rec
);

    localparam int POS_W = $clog2(MAX_TEXT_LEN + 1);

    logic [1:0]       pc_reg, pc_next, pc_step;
    logic [7:0]       lead_reg, lead_next;
    logic [7:0]       p1_reg, p1_next;
    logic [7:0]       p2_reg, p2_next;
    logic [POS_W-1:0] bp_reg, bp_next, bp_adv;
    logic             accept;
    logic             fresh;
    logic [2:0]       need;
    logic [20:0]      rune;
    logic [7:0]       b;

    // Offset n bytes back, floored at zero
    function automatic logic [POS_W-1:0] pos_back(input logic [POS_W-1:0] pos,
                                                  input logic [1:0] n);
        logic [POS_W-1:0] nn;
        nn = POS_W'(n);
        return (pos >= nn) ? (pos - nn) : '0;
    endfunction

    assign b         = s_item.data_byte;
    assign rec_valid = s_valid;
    assign s_ready   = rec_ready;
    assign accept    = s_valid && rec_ready;

    // Classify the byte against the held sequence
    always_comb begin
        rec       = '0;
        rec.main_kind = MARK_NONE;
        pc_step   = pc_reg;
        lead_next = lead_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        fresh     = 1'b1;
        rune      = '0;
        need      = lead_length(lead_reg);
        if (pc_reg != 2'd0) begin
            fresh = 1'b0;
            if ((need != 3'd0) && continues(lead_reg, pc_reg, b)) begin
                if (({1'b0, pc_reg} + 3'd1) >= need) begin
                    case (need)
                        3'd2:    rune = {10'd0, lead_reg[4:0], b[5:0]};
                        3'd3:    rune = {5'd0, lead_reg[3:0], p1_reg[5:0], b[5:0]};
                        default: rune = {lead_reg[2:0], p1_reg[5:0], p2_reg[5:0], b[5:0]};
                    endcase
                    rec.main_kind = rune_space(rune) ? MARK_SPACE : MARK_TEXT;
                    rec.main_off  = END_W'(pos_back(bp_reg, 2'(need - 3'd1)));
                    pc_step       = 2'd0;
                end else begin
                    if (pc_reg == 2'd1) begin
                        p1_next = b;
                    end else begin
                        p2_next = b;
                    end
                    pc_step = pc_reg + 2'd1;
                end
            end else begin
                rec.err_lead = 1'b1;
                rec.err_off  = START_W'(pos_back(bp_reg, pc_reg));
                pc_step      = 2'd0;
                fresh        = 1'b1;
            end
        end
        if (fresh) begin
            if (!b[7]) begin
                rec.main_kind = ascii_space(b) ? MARK_SPACE : MARK_TEXT;
                rec.main_off  = END_W'(bp_reg);
            end else if (lead_length(b) != 3'd0) begin
                lead_next = b;
                pc_step   = 2'd1;
            end else begin
                rec.main_kind = MARK_TEXT;
                rec.main_off  = END_W'(bp_reg);
            end
        end

        // Advance the offset, saturating at the length limit
        bp_adv = (bp_reg < POS_W'(MAX_TEXT_LEN)) ? (bp_reg + POS_W'(1)) : bp_reg;

        // Close out the stream on its last byte
        rec.last       = s_item.end_of_text;
        rec.tail_valid = s_item.end_of_text && (pc_step != 2'd0);
        rec.tail_off   = START_W'(pos_back(bp_adv, pc_step));
        rec.end_off    = END_W'(bp_adv);
        pc_next        = s_item.end_of_text ? 2'd0 : pc_step;
        bp_next        = s_item.end_of_text ? '0 : bp_adv;
    end

    // Update counters on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 2'd0;
            bp_reg <= '0;
        end else if (accept) begin
            pc_reg <= pc_next;
            bp_reg <= bp_next;
        end
    end

    // Hold the bytes of an incomplete sequence
    always_ff @(posedge aclk) begin
        if (accept) begin
            lead_reg <= lead_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
        end
    end

endmodule

// ===== sv/uwfs_queue.sv =====
// Short record queue between the front and the back of the splitter.
module uwfs_queue
    import uwfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  step_rec_t in_rec,
    output logic      out_valid,
    input  logic      out_ready,
    output step_rec_t out_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    step_rec_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_rec   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming record
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_rec;
        end
    end

endmodule

// ===== sv/uwfs_back.sv =====
// Back of the splitter: field tracking and the registered result item.
module uwfs_back
    import uwfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      rec_valid,
    output logic      rec_ready,
    input  step_rec_t rec,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic               open_reg, open_next;
    logic [START_W-1:0] start_reg, start_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;
    logic               emit;
    logic               pop;

    assign rec_ready = !out_valid_reg || m_ready;
    assign pop       = rec_valid && rec_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // Apply the record's characters in order; at most one result per item
    always_comb begin
        open_next     = open_reg;
        start_next    = start_reg;
        emit          = 1'b0;
        out_item_next = out_item_reg;
        if (rec.err_lead && !open_next) begin
            open_next  = 1'b1;
            start_next = rec.err_off;
        end
        case (rec.main_kind)
            MARK_SPACE: begin
                if (open_next) begin
                    emit                        = 1'b1;
                    out_item_next.field_start   = start_next;
                    out_item_next.field_end     = rec.main_off;
                    out_item_next.closes_stream = 1'b0;
                end
                open_next = 1'b0;
            end
            MARK_TEXT: begin
                if (!open_next) begin
                    open_next  = 1'b1;
                    start_next = rec.main_off[START_W-1:0];
                end
            end
            default: ;
        endcase
        if (rec.tail_valid && !open_next) begin
            open_next  = 1'b1;
            start_next = rec.tail_off;
        end
        if (rec.last) begin
            if (open_next && !emit) begin
                emit                        = 1'b1;
                out_item_next.field_start   = start_next;
                out_item_next.field_end     = rec.end_off;
                out_item_next.closes_stream = 1'b1;
            end
            open_next  = 1'b0;
            start_next = '0;
        end
    end

    // Load a result on pop, drop the shown one once taken
    always_comb begin
        if (pop) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                open_reg <= open_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            start_reg <= start_next;
            if (emit) begin
                out_item_reg <= out_item_next;
            end
        end
    end

endmodule

// ===== sv/utf8_whitespace_field_splitter.sv =====
// Top level of the UTF-8 whitespace field splitter.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | in_item_t  (data_byte, end_of_text)
//  m_      | out | m_valid / m_ready  | out_item_t (field_start, field_end, closes_stream)
//
// One byte is taken every cycle while s_ready is high; the front decodes it in the cycle it is accepted.
// The result of a closing byte passes through a two-entry queue
// and then the back's output register on its way to m_.
// Reset (aresetn low, synchronous) empties the queue, the output and the stream state.
// A stalled m_ side fills the queue, then s_ready drops until the result is taken.
module utf8_whitespace_field_splitter
    import uwfs_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      f_valid, f_ready;
    step_rec_t f_rec;
    logic      q_valid, q_ready;
    step_rec_t q_rec;

    uwfs_front #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .rec_valid (f_valid),
        .rec_ready (f_ready),
        .rec       (f_rec)
    );

    uwfs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_rec    (f_rec),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rec   (q_rec)
    );

    uwfs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_valid),
        .rec_ready (q_ready),
        .rec       (q_rec),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== sv/uwfs_checker.sv =====
// Port-level checker of the splitter and its bind to the top level.
`include "assert_macros.svh"

module uwfs_checker
    import uwfs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A stalled result holds
    `UWFS_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_item), "m_ item changed under stall")

    // With the output empty the back drains, so the queue has room
    `UWFS_ASSERT_NOW(a_no_false_stall, !m_valid, s_ready, "s_ready low with empty output")

    // Reset clears the output
    `UWFS_ASSERT_RST(a_reset_clears, !aresetn, !m_valid, "m_valid high after reset")

endmodule

bind utf8_whitespace_field_splitter uwfs_checker u_checker (.*);
